// ===== hdl/bhtwa_pkg.sv =====
package bhtwa_pkg;

  typedef enum logic [1:0] {
    CMD_PROBE      = 2'd0,
    CMD_STORE      = 2'd1,
    CMD_NEW_SEARCH = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    BOUND_NONE  = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_EXACT = 2'd3
  } bound_e;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned MOVE_IN_W  = 16;
  localparam int unsigned SCORE_IN_W = 32;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned DEPTH_IN_W = 16;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned GEN_W      = 6;
  localparam int unsigned BOUND_W    = 2;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned WAY_W      = 2;
  localparam int unsigned WORTH_W    = 10;

  localparam logic [GEN_W-1:0]   GEN_MAX   = 6'd63;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic in_load;
    logic rd_en;
    logic rd_from_in;
    logic finish;
    logic sweep_en;
  } dp_ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic idx_direct;
    logic mod_done;
    logic sweep_last;
    logic need_clear;
  } dp_sts_t;

endpackage

// ===== hdl/bhtwa_ram.sv =====
module bhtwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bhtwa_dp.sv =====
module bhtwa_dp #(
  parameter int unsigned CLUSTERS  = 1024,
  parameter int unsigned MOVE_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  bhtwa_pkg::dp_ctl_t                           ctl_i,
  output bhtwa_pkg::dp_sts_t                           sts_o,
  input  logic [1:0]                                   cmd_i,
  input  logic [bhtwa_pkg::KEY_W-1:0]                  key_i,
  input  logic [bhtwa_pkg::MOVE_IN_W-1:0]              move_word_i,
  input  logic signed [bhtwa_pkg::SCORE_IN_W-1:0]      score_in_i,
  input  logic signed [bhtwa_pkg::DEPTH_IN_W-1:0]      depth_in_i,
  input  logic [bhtwa_pkg::BOUND_W-1:0]                bound_in_i,
  output logic                                         hit_o,
  output logic [bhtwa_pkg::MOVE_IN_W-1:0]              move_out_o,
  output logic signed [bhtwa_pkg::SCORE_W-1:0]         score_out_o,
  output logic [bhtwa_pkg::DEPTH_W-1:0]                depth_out_o,
  output logic [bhtwa_pkg::BOUND_W-1:0]                bound_out_o,
  output logic                                         written_o
);

  localparam int unsigned IDX_W     = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int unsigned BOUND_LSB = 0;
  localparam int unsigned GEN_LSB   = BOUND_LSB + bhtwa_pkg::BOUND_W;
  localparam int unsigned DEPTH_LSB = GEN_LSB + bhtwa_pkg::GEN_W;
  localparam int unsigned SCORE_LSB = DEPTH_LSB + bhtwa_pkg::DEPTH_W;
  localparam int unsigned MOVE_LSB  = SCORE_LSB + bhtwa_pkg::SCORE_W;
  localparam int unsigned KEY_LSB   = MOVE_LSB + MOVE_BITS;
  localparam int unsigned SLOT_W    = KEY_LSB + bhtwa_pkg::KEY_W;
  localparam int unsigned ROW_W     = bhtwa_pkg::WAYS * SLOT_W;
  localparam bit          IS_POW2   = ((CLUSTERS & (CLUSTERS - 1)) == 0);
  localparam logic [bhtwa_pkg::KEY_W-1:0] KEY_MASK = bhtwa_pkg::KEY_W'(CLUSTERS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CLUSTERS - 1);

  bhtwa_pkg::cmd_e                    cmd_q;
  bhtwa_pkg::bound_e                  bound_q;
  logic [bhtwa_pkg::KEY_W-1:0]        key_q;
  logic [MOVE_BITS-1:0]               move_q;
  logic [bhtwa_pkg::SCORE_W-1:0]      score_q;
  logic [bhtwa_pkg::DEPTH_W-1:0]      depth_q;
  logic signed [bhtwa_pkg::DEPTH_IN_W-1:0] depth_raw_q;

  logic [31:0]                        move_ext;
  logic [bhtwa_pkg::SCORE_W-1:0]      score_sat;
  logic [bhtwa_pkg::DEPTH_W-1:0]      depth_sat;

  logic [IDX_W-1:0]                   idx_in;
  logic [IDX_W-1:0]                   idx_cur;
  logic                               mod_done;
  logic [IDX_W-1:0]                   sweep_q;
  logic [bhtwa_pkg::GEN_W-1:0]        gen_q;

  logic [ROW_W-1:0]                   row_q;
  logic [ROW_W-1:0]                   new_row;
  logic [SLOT_W-1:0]                  new_slot;
  logic                               ram_we;
  logic [IDX_W-1:0]                   ram_waddr;
  logic [ROW_W-1:0]                   ram_wdata;
  logic [IDX_W-1:0]                   ram_raddr;

  logic [bhtwa_pkg::KEY_W-1:0]        w_key   [bhtwa_pkg::WAYS];
  logic [MOVE_BITS-1:0]               w_move  [bhtwa_pkg::WAYS];
  logic [bhtwa_pkg::SCORE_W-1:0]      w_score [bhtwa_pkg::WAYS];
  logic [bhtwa_pkg::DEPTH_W-1:0]      w_depth [bhtwa_pkg::WAYS];
  logic [bhtwa_pkg::GEN_W-1:0]        w_age   [bhtwa_pkg::WAYS];
  logic [bhtwa_pkg::BOUND_W-1:0]      w_bound [bhtwa_pkg::WAYS];
  logic signed [bhtwa_pkg::WORTH_W-1:0] w_worth [bhtwa_pkg::WAYS];
  logic [bhtwa_pkg::WAYS-1:0]         w_valid;
  logic [bhtwa_pkg::WAYS-1:0]         w_match;

  logic                               probe_hit;
  logic [bhtwa_pkg::WAY_W-1:0]        hit_way;
  logic [bhtwa_pkg::WAY_W-1:0]        rep_way;
  logic                               rep_found;
  logic signed [bhtwa_pkg::DEPTH_IN_W+1:0] depth_margin;
  logic                               skip;
  logic                               do_write;
  logic [31:0]                        hit_move_ext;

  logic                               hit_q;
  logic [bhtwa_pkg::MOVE_IN_W-1:0]    move_out_q;
  logic [bhtwa_pkg::SCORE_W-1:0]      score_out_q;
  logic [bhtwa_pkg::DEPTH_W-1:0]      depth_out_q;
  logic [bhtwa_pkg::BOUND_W-1:0]      bound_out_q;
  logic                               written_q;

  // Input capture with saturation done on the way in.
  assign move_ext = {{(32 - bhtwa_pkg::MOVE_IN_W){1'b0}}, move_word_i};

  always_comb begin
    if (&score_in_i[bhtwa_pkg::SCORE_IN_W-1:bhtwa_pkg::SCORE_W-1] ||
        ~|score_in_i[bhtwa_pkg::SCORE_IN_W-1:bhtwa_pkg::SCORE_W-1]) begin
      score_sat = score_in_i[bhtwa_pkg::SCORE_W-1:0];
    end else if (score_in_i[bhtwa_pkg::SCORE_IN_W-1]) begin
      score_sat = {1'b1, {(bhtwa_pkg::SCORE_W-1){1'b0}}};
    end else begin
      score_sat = {1'b0, {(bhtwa_pkg::SCORE_W-1){1'b1}}};
    end
    if (depth_in_i[bhtwa_pkg::DEPTH_IN_W-1]) begin
      depth_sat = '0;
    end else if (|depth_in_i[bhtwa_pkg::DEPTH_IN_W-2:bhtwa_pkg::DEPTH_W]) begin
      depth_sat = bhtwa_pkg::DEPTH_MAX;
    end else begin
      depth_sat = depth_in_i[bhtwa_pkg::DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.in_load) begin
      cmd_q       <= bhtwa_pkg::cmd_e'(cmd_i);
      bound_q     <= bhtwa_pkg::bound_e'(bound_in_i);
      key_q       <= key_i;
      move_q      <= move_ext[MOVE_BITS-1:0];
      score_q     <= score_sat;
      depth_q     <= depth_sat;
      depth_raw_q <= depth_in_i;
    end
  end

  assign idx_in = IDX_W'(key_i & KEY_MASK);

  if (IS_POW2) begin : g_pow2
    logic [IDX_W-1:0] idx_q;

    always_ff @(posedge clk_i) begin
      if (ctl_i.in_load) begin
        idx_q <= idx_in;
      end
    end

    assign idx_cur  = idx_q;
    assign mod_done = 1'b1;
  end else begin : g_mod
    localparam int unsigned R_W     = IDX_W + 1;
    localparam int unsigned CHUNK_W = 8;
    localparam int unsigned CHUNKS  = bhtwa_pkg::KEY_W / CHUNK_W;
    localparam int unsigned STEP_W  = $clog2(CHUNKS);
    localparam logic [R_W-1:0]    MODULUS   = R_W'(CLUSTERS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHUNKS - 1);

    logic [R_W-1:0]              rem_q;
    logic [R_W-1:0]              rem_d;
    logic [bhtwa_pkg::KEY_W-1:0] kbits_q;
    logic [STEP_W-1:0]           step_q;
    logic                        busy_q;

    // Remainder by the cluster count, one key byte per cycle from the top.
    always_comb begin
      rem_d = rem_q;
      for (int b = 0; b < CHUNK_W; b++) begin
        rem_d = {rem_d[R_W-2:0], kbits_q[bhtwa_pkg::KEY_W-1-b]};
        if (rem_d >= MODULUS) begin
          rem_d = rem_d - MODULUS;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else if (ctl_i.in_load) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.in_load) begin
        rem_q   <= '0;
        kbits_q <= key_i;
      end else if (busy_q) begin
        rem_q   <= rem_d;
        kbits_q <= {kbits_q[bhtwa_pkg::KEY_W-1-CHUNK_W:0], {CHUNK_W{1'b0}}};
      end
    end

    assign idx_cur  = rem_q[IDX_W-1:0];
    assign mod_done = ~busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      gen_q   <= '0;
    end else begin
      if (ctl_i.sweep_en) begin
        sweep_q <= (sweep_q == IDX_LAST) ? '0 : sweep_q + 1'b1;
      end
      if (ctl_i.finish) begin
        if (cmd_q == bhtwa_pkg::CMD_CLEAR) begin
          gen_q <= '0;
        end else if (cmd_q == bhtwa_pkg::CMD_NEW_SEARCH) begin
          gen_q <= (gen_q == bhtwa_pkg::GEN_MAX) ? '0 : gen_q + 1'b1;
        end
      end
    end
  end

  // Slot decode and replacement choice over the four ways.
  always_comb begin
    for (int w = 0; w < bhtwa_pkg::WAYS; w++) begin
      w_key[w]   = row_q[w*SLOT_W + KEY_LSB +: bhtwa_pkg::KEY_W];
      w_move[w]  = row_q[w*SLOT_W + MOVE_LSB +: MOVE_BITS];
      w_score[w] = row_q[w*SLOT_W + SCORE_LSB +: bhtwa_pkg::SCORE_W];
      w_depth[w] = row_q[w*SLOT_W + DEPTH_LSB +: bhtwa_pkg::DEPTH_W];
      w_age[w]   = gen_q - row_q[w*SLOT_W + GEN_LSB +: bhtwa_pkg::GEN_W];
      w_bound[w] = row_q[w*SLOT_W + BOUND_LSB +: bhtwa_pkg::BOUND_W];
      w_valid[w] = (w_bound[w] != bhtwa_pkg::BOUND_NONE);
      w_match[w] = (w_key[w] == key_q);
      w_worth[w] = $signed({2'b00, w_depth[w]}) - $signed({1'b0, w_age[w], 3'b000});
    end

    probe_hit = 1'b0;
    hit_way   = '0;
    for (int w = 0; w < bhtwa_pkg::WAYS; w++) begin
      if (!probe_hit && w_valid[w] && w_match[w]) begin
        probe_hit = 1'b1;
        hit_way   = bhtwa_pkg::WAY_W'(w);
      end
    end

    rep_found = 1'b0;
    rep_way   = '0;
    for (int w = 0; w < bhtwa_pkg::WAYS; w++) begin
      if (!rep_found) begin
        if (!w_valid[w] || w_match[w]) begin
          rep_way   = bhtwa_pkg::WAY_W'(w);
          rep_found = 1'b1;
        end else if (w_worth[w] < w_worth[rep_way]) begin
          rep_way = bhtwa_pkg::WAY_W'(w);
        end
      end
    end

    // A much shallower non-exact result for the same key keeps its entry.
    depth_margin = {{2{depth_raw_q[bhtwa_pkg::DEPTH_IN_W-1]}}, depth_raw_q} + 18'sd2;
    skip = w_valid[rep_way] && w_match[rep_way] &&
           (depth_margin < $signed({10'b0, w_depth[rep_way]})) &&
           (bound_q != bhtwa_pkg::BOUND_EXACT);
    do_write = (cmd_q == bhtwa_pkg::CMD_STORE) && (bound_q != bhtwa_pkg::BOUND_NONE) && !skip;

    new_slot = {key_q, move_q, score_q, depth_q, gen_q, bound_q};
    new_row  = row_q;
    new_row[rep_way*SLOT_W +: SLOT_W] = new_slot;
  end

  assign ram_we    = ctl_i.sweep_en | (ctl_i.finish & do_write);
  assign ram_waddr = ctl_i.sweep_en ? sweep_q : idx_cur;
  assign ram_wdata = ctl_i.sweep_en ? '0 : new_row;
  assign ram_raddr = ctl_i.rd_from_in ? idx_in : idx_cur;

  bhtwa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CLUSTERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (row_q)
  );

  assign hit_move_ext = 32'(w_move[hit_way]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      if ((cmd_q == bhtwa_pkg::CMD_PROBE) && probe_hit) begin
        hit_q       <= 1'b1;
        move_out_q  <= hit_move_ext[bhtwa_pkg::MOVE_IN_W-1:0];
        score_out_q <= w_score[hit_way];
        depth_out_q <= w_depth[hit_way];
        bound_out_q <= w_bound[hit_way];
      end else begin
        hit_q       <= 1'b0;
        move_out_q  <= '0;
        score_out_q <= '0;
        depth_out_q <= '0;
        bound_out_q <= bhtwa_pkg::BOUND_NONE;
      end
      written_q <= do_write;
    end
  end

  assign hit_o       = hit_q;
  assign move_out_o  = move_out_q;
  assign score_out_o = score_out_q;
  assign depth_out_o = depth_out_q;
  assign bound_out_o = bound_out_q;
  assign written_o   = written_q;

  assign sts_o.idx_direct = IS_POW2;
  assign sts_o.mod_done   = mod_done;
  assign sts_o.sweep_last = (sweep_q == IDX_LAST);
  assign sts_o.need_clear = (cmd_q == bhtwa_pkg::CMD_CLEAR) ||
                            ((cmd_q == bhtwa_pkg::CMD_NEW_SEARCH) &&
                             (gen_q == bhtwa_pkg::GEN_MAX));

  a_gen_zero_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.sweep_en |-> gen_q == '0)
    else $error("Generation is not zero while the table is being cleared.");

  a_sweep_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.sweep_en |-> !ctl_i.rd_en && !ctl_i.finish && !ctl_i.in_load)
    else $error("Clearing pass overlaps a transaction.");

  a_no_write_without_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.finish && (cmd_q == bhtwa_pkg::CMD_STORE) && (bound_q == bhtwa_pkg::BOUND_NONE)
    |=> !written_q)
    else $error("Store without a bound reported a write.");

endmodule

// ===== hdl/bhtwa_ctrl.sv =====
module bhtwa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bhtwa_pkg::dp_ctl_t ctl_o,
  input  bhtwa_pkg::dp_sts_t sts_i
);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_INDEX = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0]         state_q;
  logic [1:0]         state_d;
  logic               out_valid_q;
  logic               out_valid_d;
  logic               out_free;
  logic               accept;
  bhtwa_pkg::dp_ctl_t ctl;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ctl     = '0;
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        ctl.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ctl.in_load = 1'b1;
          if (sts_i.idx_direct) begin
            ctl.rd_en      = 1'b1;
            ctl.rd_from_in = 1'b1;
            state_d        = S_EVAL;
          end else begin
            state_d = S_INDEX;
          end
        end
      end
      S_INDEX: begin
        if (sts_i.mod_done) begin
          ctl.rd_en = 1'b1;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_d    = sts_i.need_clear ? S_SWEEP : S_IDLE;
        end
      end
      default: begin
        state_d = S_SWEEP;
      end
    endcase
    out_valid_d = ctl.finish | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctl_o       = ctl;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("Accepted transaction did not occupy the controller.");

  a_sweep_runs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) && !sts_i.sweep_last |=> state_q == S_SWEEP)
    else $error("Clearing pass ended before the last cluster.");

  a_eval_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) && !out_free |=> (state_q == S_EVAL) && out_valid_q)
    else $error("Result finished while the output register was still full.");

endmodule

// ===== hdl/bucketed_hash_table_with_aging.sv =====
// Four-way bucketed hash table with generation aging. Each transaction carries a
// probe, a store, a new-search or a clear command and returns exactly one result
// transaction. With a power-of-two CLUSTERS the block reads the cluster row
// from the single-port-read row memory, then picks the way, writes the row
// back and registers the result once the output register is free. Otherwise
// the cluster index is first computed as a remainder, one key byte per cycle.
// After reset, after a clear command and after a new search that wraps the
// generation, the block clears every cluster of the memory, one per cycle, and
// holds in_ready_o low meanwhile. A result waiting in the output register does
// not block the next input transaction from being accepted.
module bucketed_hash_table_with_aging #(
  parameter int unsigned CLUSTERS  = 1024,
  parameter int unsigned MOVE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              cmd_i,
  input  logic [bhtwa_pkg::KEY_W-1:0]             key_i,
  input  logic [bhtwa_pkg::MOVE_IN_W-1:0]         move_word_i,
  input  logic signed [bhtwa_pkg::SCORE_IN_W-1:0] score_in_i,
  input  logic signed [bhtwa_pkg::DEPTH_IN_W-1:0] depth_in_i,
  input  logic [bhtwa_pkg::BOUND_W-1:0]           bound_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    hit_o,
  output logic [bhtwa_pkg::MOVE_IN_W-1:0]         move_out_o,
  output logic signed [bhtwa_pkg::SCORE_W-1:0]    score_out_o,
  output logic [bhtwa_pkg::DEPTH_W-1:0]           depth_out_o,
  output logic [bhtwa_pkg::BOUND_W-1:0]           bound_out_o,
  output logic                                    written_o
);

  bhtwa_pkg::dp_ctl_t ctl;
  bhtwa_pkg::dp_sts_t sts;

  bhtwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  bhtwa_dp #(
    .CLUSTERS  (CLUSTERS),
    .MOVE_BITS (MOVE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .move_word_i (move_word_i),
    .score_in_i  (score_in_i),
    .depth_in_i  (depth_in_i),
    .bound_in_i  (bound_in_i),
    .hit_o       (hit_o),
    .move_out_o  (move_out_o),
    .score_out_o (score_out_o),
    .depth_out_o (depth_out_o),
    .bound_out_o (bound_out_o),
    .written_o   (written_o)
  );

endmodule
